FILE: rtl/two_key_press_classifier_assert.svh
// Assertion helpers for the two-key press classifier.
`ifndef TWO_KEY_PRESS_CLASSIFIER_ASSERT_SVH
`define TWO_KEY_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define TKPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen outside reset.
`define TKPC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TKPC_ASSERT(label, clk, rst_n, prop, msg)
`define TKPC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: rtl/tkpc_pkg.sv
package tkpc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd800;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } reg_idx_t;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [TIME_W-1:0]   now_ms;
        logic                key1_edge;
        logic                key2_edge;
        logic                key1_released;
        logic                key2_released;
    } item_t;

    typedef struct packed {
        logic key1_short_press;
        logic key1_long_press;
        logic key2_short_press;
        logic ind1_flip;
        logic ind2_flip;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_hold_time;
    } cfg_t;

endpackage

FILE: rtl/tkpc_cfg.sv
module tkpc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tkpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [tkpc_pkg::DATA_W-1:0]   pwdata,
    output logic [tkpc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tkpc_pkg::cfg_t                cfg
);

    tkpc_pkg::cfg_t     cfg_reg;
    tkpc_pkg::cfg_t     cfg_next;
    tkpc_pkg::reg_idx_t idx;
    logic               wr_en;
    logic [tkpc_pkg::ADDR_W-1:0] addr_unused;

    // Word aligned: the two low address bits do not take part in decode
    assign addr_unused = paddr;
    assign idx   = tkpc_pkg::reg_idx_t'(addr_unused[2]);
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                tkpc_pkg::REG_DEBOUNCE:
                    cfg_next.debounce_time  = pwdata[tkpc_pkg::CFG_W-1:0];
                tkpc_pkg::REG_LONG_PRESS:
                    cfg_next.long_hold_time = pwdata[tkpc_pkg::CFG_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tkpc_pkg::REG_DEBOUNCE:
                prdata = {{(tkpc_pkg::DATA_W-tkpc_pkg::CFG_W){1'b0}}, cfg_reg.debounce_time};
            tkpc_pkg::REG_LONG_PRESS:
                prdata = {{(tkpc_pkg::DATA_W-tkpc_pkg::CFG_W){1'b0}}, cfg_reg.long_hold_time};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time  <= tkpc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_hold_time <= tkpc_pkg::LONG_PRESS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/tkpc_keys.sv
module tkpc_keys (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  tkpc_pkg::item_t   item,
    input  tkpc_pkg::cfg_t    cfg,
    output tkpc_pkg::result_t res
);

    logic [tkpc_pkg::TIME_W-1:0] key1_time_reg, key1_time_next;
    logic [tkpc_pkg::TIME_W-1:0] key2_time_reg, key2_time_next;
    logic key1_down_reg, key1_down_next;
    logic key2_down_reg, key2_down_next;
    logic key2_done_reg, key2_done_next;

    logic [tkpc_pkg::TIME_W-1:0] dt1, dt2, deb, lng;
    logic over1, over2, reach2, below_long1;
    logic rel1;

    // wrapping elapsed time since each key's last accepted press
    assign dt1 = item.now_ms - key1_time_reg;
    assign dt2 = item.now_ms - key2_time_reg;
    assign deb = {{(tkpc_pkg::TIME_W-tkpc_pkg::CFG_W){1'b0}}, cfg.debounce_time};
    assign lng = {{(tkpc_pkg::TIME_W-tkpc_pkg::CFG_W){1'b0}}, cfg.long_hold_time};

    assign over1       = dt1 > deb;
    assign over2       = dt2 > deb;
    assign reach2      = dt2 >= deb;
    assign below_long1 = dt1 < lng;
    assign rel1        = key1_down_reg && item.key1_released;

    always_comb begin
        key1_time_next = key1_time_reg;
        key2_time_next = key2_time_reg;
        key1_down_next = key1_down_reg;
        key2_down_next = key2_down_reg;
        key2_done_next = key2_done_reg;
        res            = '0;
        unique case (item.opcode)
            tkpc_pkg::OP_EDGE: begin
                if (item.key1_edge && over1) begin
                    key1_time_next = item.now_ms;
                    key1_down_next = 1'b1;
                    res.ind1_flip  = 1'b1;
                end
                if (item.key2_edge && over2) begin
                    key2_time_next = item.now_ms;
                    key2_down_next = 1'b1;
                    key2_done_next = 1'b0;
                    res.ind2_flip  = 1'b1;
                end
            end
            tkpc_pkg::OP_TICK: begin
                if (rel1) begin
                    key1_down_next        = 1'b0;
                    res.key1_short_press  = over1 && below_long1;
                    res.key1_long_press   = over1 && !below_long1;
                end
                if (key2_down_reg) begin
                    // report and release may fall on the same tick
                    if (!key2_done_reg && reach2) begin
                        res.key2_short_press = 1'b1;
                        key2_done_next       = 1'b1;
                    end
                    if (item.key2_released) begin
                        key2_down_next = 1'b0;
                        key2_done_next = 1'b0;
                    end
                end
            end
            default: res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key1_time_reg <= '0;
            key2_time_reg <= '0;
            key1_down_reg <= 1'b0;
            key2_down_reg <= 1'b0;
            key2_done_reg <= 1'b0;
        end else if (step) begin
            key1_time_reg <= key1_time_next;
            key2_time_reg <= key2_time_next;
            key1_down_reg <= key1_down_next;
            key2_down_reg <= key2_down_next;
            key2_done_reg <= key2_done_next;
        end
    end

endmodule

FILE: rtl/two_key_press_classifier.sv
// A word accepted into the input register is classified and then registered into the result register.
// Throughput: one word per cycle; s_ready falls only while both the input and result
// registers are full and m_ready is low.
// Reset (aresetn low, synchronous): both registers empty, keys released, press times zero,
// debounce window 20 ms and long-press threshold 800 ms.
`include "two_key_press_classifier_assert.svh"

module two_key_press_classifier (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [tkpc_pkg::TIME_W-1:0] s_now_ms,
    input  logic                        s_key1_edge,
    input  logic                        s_key2_edge,
    input  logic                        s_key1_released,
    input  logic                        s_key2_released,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_key1_short_press,
    output logic                        m_key1_long_press,
    output logic                        m_key2_short_press,
    output logic                        m_ind1_flip,
    output logic                        m_ind2_flip,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tkpc_pkg::ADDR_W-1:0] paddr,
    input  logic [tkpc_pkg::DATA_W-1:0] pwdata,
    output logic [tkpc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    tkpc_pkg::cfg_t    cfg;
    tkpc_pkg::item_t   in_item_reg, in_item_next;
    logic              in_valid_reg, in_valid_next;
    tkpc_pkg::result_t out_res_reg, out_res_next;
    logic              out_valid_reg, out_valid_next;
    tkpc_pkg::result_t res;
    logic              advance;
    logic              step;

    // Result register frees when empty or being taken; the input register then
    // drains into it, so both can move in the same cycle.
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    tkpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Classification and key state; state moves only when a word goes through.
    tkpc_keys u_keys (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Input register: loads a new word whenever it is ready.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_ready) begin
            in_valid_next              = s_valid;
            in_item_next.opcode        = tkpc_pkg::opcode_t'(s_opcode);
            in_item_next.now_ms        = s_now_ms;
            in_item_next.key1_edge     = s_key1_edge;
            in_item_next.key2_edge     = s_key2_edge;
            in_item_next.key1_released = s_key1_released;
            in_item_next.key2_released = s_key2_released;
        end
    end

    // Result register: holds while the consumer stalls.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
            out_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_valid            = out_valid_reg;
    assign m_key1_short_press = out_res_reg.key1_short_press;
    assign m_key1_long_press  = out_res_reg.key1_long_press;
    assign m_key2_short_press = out_res_reg.key2_short_press;
    assign m_ind1_flip        = out_res_reg.ind1_flip;
    assign m_ind2_flip        = out_res_reg.ind2_flip;

    // A key 1 release is never reported as both short and long.
    `TKPC_ASSERT_NEVER(a_key1_one_class, aclk, aresetn,
        out_valid_reg && out_res_reg.key1_short_press && out_res_reg.key1_long_press,
        "key 1 short and long together")
    // Ticks never toggle the indicators.
    `TKPC_ASSERT(a_tick_no_led, aclk, aresetn,
        (step && in_item_reg.opcode == tkpc_pkg::OP_TICK)
            |=> (!out_res_reg.ind1_flip && !out_res_reg.ind2_flip),
        "indicator toggle on a tick")
    // Edge events never report a press class.
    `TKPC_ASSERT(a_edge_no_class, aclk, aresetn,
        (step && in_item_reg.opcode == tkpc_pkg::OP_EDGE)
            |=> (!out_res_reg.key1_short_press && !out_res_reg.key1_long_press
                 && !out_res_reg.key2_short_press),
        "press report on an edge event")
    // An empty result register never holds up the input side.
    `TKPC_ASSERT(a_ready_when_empty, aclk, aresetn, !out_valid_reg |-> s_ready,
        "input stalled with result register empty")
    // A word in the input register reaches the result register when it drains.
    `TKPC_ASSERT(a_step_fills_out, aclk, aresetn, step |=> out_valid_reg,
        "result lost after step")

endmodule
